[rtl/u8tt_pkg.sv]
// ----------------------------------------------------------------------------
// u8tt_pkg
// Shared types and constants of the UTF-8 character table transliterator.
// ----------------------------------------------------------------------------
package u8tt_pkg;

   // request field layout
   localparam int REQ_TDATA_W  = 96;
   localparam int BYTE_W       = 8;
   localparam int INDEX_W      = 6;
   localparam int LEN_W        = 4;
   localparam int SRC_W        = 64;
   localparam int CFG_W        = 7;

   localparam int DATA_LSB     = 0;
   localparam int INDEX_LSB    = 8;
   localparam int TARGET_LSB   = 14;
   localparam int LENGTH_LSB   = 22;
   localparam int SOURCE_LSB   = 26;

   // request kinds carried in tuser
   localparam logic REQ_DATA   = 1'b0;
   localparam logic REQ_LOAD   = 1'b1;

   // character codes
   localparam logic [7:0] CODE_CR    = 8'h0D;
   localparam logic [7:0] CODE_LF    = 8'h0A;
   localparam logic [7:0] CODE_SPACE = 8'h20;
   localparam logic [7:0] CODE_TAB   = 8'h09;

   // output byte source
   localparam logic [1:0] OUT_SEL_NL  = 2'd0;
   localparam logic [1:0] OUT_SEL_TGT = 2'd1;
   localparam logic [1:0] OUT_SEL_CHR = 2'd2;

   typedef struct packed {
      logic [SRC_W-1:0]  source;
      logic [LEN_W-1:0]  length;
      logic [BYTE_W-1:0] target;
   } entry_type;

   typedef struct packed {
      logic       take;        // request accepted this cycle
      logic       scan_start;  // clear scan and emit counters
      logic       scan_step;   // read next table entry
      logic       out_load;    // load output register
      logic [1:0] out_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic char_done;   // a data request now would complete the character
      logic is_cr;
      logic is_blank;    // one-byte LF, space or tab
      logic issued_all;
      logic cmp_valid;
      logic cmp_match;
      logic out_free;
      logic emit_last;
   } dp_status_type;

   // number of leading one bits of a lead byte
   function automatic logic [LEN_W-1:0] lead_ones(input logic [7:0] b);
      logic             run;
      logic [LEN_W-1:0] n;
      run = 1'b1;
      n   = '0;
      for (int i = 7; i >= 0; i--) begin
         run = run & b[i];
         n   = n + LEN_W'(run);
      end
      return n;
   endfunction

endpackage

[rtl/utf8_char_table_transliterator.sv]
// ----------------------------------------------------------------------------
// utf8_char_table_transliterator
// Groups a byte stream into UTF-8 characters and maps each through a table.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  req      in   req_tvalid/tready  tdata: byte, table entry; tuser: kind
//  rsp      out  rsp_tvalid/tready  tdata: out byte; tlast: last of run
//  csr      in   csr_valid/ready    csr_data: entry count
//
//  Bytes that do not finish a character and table loads leave req ready.
//  A finished character is accepted and classified, then a table scan reads
//  up to min(entry_count, TABLE_DEPTH) entries through the single read port,
//  then the result is emitted (1 to 8 bytes); CR and blanks skip the scan.
//  Reset clears control state only; table contents are undefined until loaded.
//  A stalled rsp side holds the output register; req waits while busy.
// ----------------------------------------------------------------------------
module utf8_char_table_transliterator #(
   parameter int TABLE_DEPTH    = 64,
   parameter int MAX_CHAR_BYTES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // data_byte, entry_index, entry_target, entry_length, entry_source, pad
   input  logic [u8tt_pkg::REQ_TDATA_W-1:0] req_tdata,
   // req_type
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // out_byte
   output logic [7:0]                       rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [u8tt_pkg::CFG_W-1:0]       csr_data
);
   import u8tt_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type sts;

   u8tt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   u8tt_datapath #(
      .TABLE_DEPTH    (TABLE_DEPTH),
      .MAX_CHAR_BYTES (MAX_CHAR_BYTES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .cmd        (cmd),
      .sts        (sts)
   );

endmodule

[rtl/u8tt_datapath.sv]
// ----------------------------------------------------------------------------
// u8tt_datapath
// Character collection, entry table, serial table compare and output register.
// ----------------------------------------------------------------------------
module u8tt_datapath #(
   parameter int TABLE_DEPTH    = 64,
   parameter int MAX_CHAR_BYTES = 8
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [u8tt_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [7:0]                       rsp_tdata,
   output logic                             rsp_tlast,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [u8tt_pkg::CFG_W-1:0]       csr_data,
   input  u8tt_pkg::ctrl_cmd_type           cmd,
   output u8tt_pkg::dp_status_type          sts
);
   import u8tt_pkg::*;

   localparam int AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CntW  = $clog2(TABLE_DEPTH + 1);
   localparam int LimW  = (CntW > CFG_W) ? CntW : CFG_W;
   localparam int HW    = $clog2(MAX_CHAR_BYTES + 1);
   localparam int ChW   = $clog2(MAX_CHAR_BYTES);

   logic [BYTE_W-1:0]  data_byte;
   logic [INDEX_W-1:0] entry_index;
   entry_type          wr_entry;

   logic [CFG_W-1:0]   count_ff;
   logic [HW-1:0]      held_ff, held_in;
   logic [HW-1:0]      expected_ff, expected_in;
   logic [BYTE_W-1:0]  char_ff [MAX_CHAR_BYTES];
   logic [CntW-1:0]    scan_ff, scan_in;
   logic [HW-1:0]      emit_ff, emit_in;
   logic               rd_vld_ff;
   entry_type          rd_q_ff;
   entry_type          table_mem [TABLE_DEPTH];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [LEN_W-1:0]   lead_n;
   logic [HW-1:0]      lead_len;
   logic [HW-1:0]      exp_new;
   logic               take_data, take_load, done_now;
   logic [8:0]         idx_ext;
   logic [LimW-1:0]    limit;
   logic               match;

   assign data_byte       = req_tdata[DATA_LSB +: BYTE_W];
   assign entry_index     = req_tdata[INDEX_LSB +: INDEX_W];
   assign wr_entry.target = req_tdata[TARGET_LSB +: BYTE_W];
   assign wr_entry.length = req_tdata[LENGTH_LSB +: LEN_W];
   assign wr_entry.source = req_tdata[SOURCE_LSB +: SRC_W];
   assign idx_ext         = {3'b000, entry_index};

   assign take_data = cmd.take && (req_tuser == REQ_DATA);
   assign take_load = cmd.take && (req_tuser == REQ_LOAD);

   // character length from the lead byte, at least one, capped
   always_comb begin
      lead_n = lead_ones(data_byte);
      if (lead_n == '0) begin
         lead_len = HW'(1);
      end else if (32'(lead_n) > MAX_CHAR_BYTES) begin
         lead_len = HW'(MAX_CHAR_BYTES);
      end else begin
         lead_len = HW'(lead_n);
      end
      exp_new  = (held_ff == '0) ? lead_len : expected_ff;
      done_now = ((HW + 1)'(held_ff) + (HW + 1)'(1)) >= (HW + 1)'(exp_new);
   end

   always_comb begin
      held_in     = held_ff;
      expected_in = expected_ff;
      if (take_data) begin
         expected_in = exp_new;
         held_in     = done_now ? '0 : held_ff + HW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff     <= '0;
         expected_ff <= '0;
         count_ff    <= '0;
      end else begin
         held_ff     <= held_in;
         expected_ff <= expected_in;
         if (csr_valid) begin
            count_ff <= csr_data;
         end
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (take_data && (32'(held_ff) < MAX_CHAR_BYTES)) begin
         char_ff[held_ff[ChW-1:0]] <= data_byte;
      end
   end

   // table memory: one write port for loads, one registered read port for the scan
   always_ff @(posedge clock) begin
      if (take_load && (32'(idx_ext) < TABLE_DEPTH)) begin
         table_mem[idx_ext[AddrW-1:0]] <= wr_entry;
      end
      if (cmd.scan_step) begin
         rd_q_ff <= table_mem[scan_ff[AddrW-1:0]];
      end
   end

   always_comb begin
      if (LimW'(count_ff) > LimW'(TABLE_DEPTH)) begin
         limit = LimW'(TABLE_DEPTH);
      end else begin
         limit = LimW'(count_ff);
      end
   end

   always_comb begin
      scan_in = scan_ff;
      emit_in = emit_ff;
      if (cmd.scan_start) begin
         scan_in = '0;
         emit_in = '0;
      end else begin
         if (cmd.scan_step) begin
            scan_in = scan_ff + CntW'(1);
         end
         if (cmd.out_load && (cmd.out_sel == OUT_SEL_CHR)) begin
            emit_in = emit_ff + HW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff   <= '0;
         emit_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         scan_ff   <= scan_in;
         emit_ff   <= emit_in;
         rd_vld_ff <= cmd.scan_step;
      end
   end

   // entry compare: length first, then only the bytes within the length
   always_comb begin
      match = (rd_q_ff.length == LEN_W'(expected_ff));
      for (int i = 0; i < MAX_CHAR_BYTES; i++) begin
         if ((i < 32'(expected_ff)) && (rd_q_ff.source[8*i +: 8] != char_ff[i])) begin
            match = 1'b0;
         end
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         case (cmd.out_sel)
            OUT_SEL_NL: begin
               rsp_data_in = CODE_LF;
               rsp_last_in = 1'b1;
            end
            OUT_SEL_TGT: begin
               rsp_data_in = rd_q_ff.target;
               rsp_last_in = 1'b1;
            end
            OUT_SEL_CHR: begin
               rsp_data_in = char_ff[emit_ff[ChW-1:0]];
               rsp_last_in = sts.emit_last;
            end
            default: begin
               rsp_data_in = CODE_LF;
               rsp_last_in = 1'b1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      sts.char_done  = (req_tuser == REQ_DATA) && done_now;
      sts.is_cr      = (expected_ff == HW'(1)) && (char_ff[0] == CODE_CR);
      sts.is_blank   = (expected_ff == HW'(1)) &&
                       ((char_ff[0] == CODE_LF) || (char_ff[0] == CODE_SPACE) ||
                        (char_ff[0] == CODE_TAB));
      sts.issued_all = (LimW'(scan_ff) == limit);
      sts.cmp_valid  = rd_vld_ff;
      sts.cmp_match  = match;
      sts.out_free   = !rsp_valid_ff || rsp_tready;
      sts.emit_last  = ((HW + 1)'(emit_ff) + (HW + 1)'(1)) == (HW + 1)'(expected_ff);
   end

`ifndef SYNTHESIS
   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && (cmd.out_sel == OUT_SEL_CHR)) |-> (emit_ff < expected_ff))
      else $error("character byte emitted beyond its length");
   a_held_below_len: assert property (@(posedge clock) disable iff (reset)
      (held_ff != '0) |-> (held_ff < expected_ff))
      else $error("collected byte count reached character length");
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |=> (LimW'(scan_ff) <= limit))
      else $error("table scan ran past the entry count");
`endif

endmodule

[rtl/u8tt_ctrl.sv]
// ----------------------------------------------------------------------------
// u8tt_ctrl
// Sequencer: collect, classify, table scan, emit.
// ----------------------------------------------------------------------------
module u8tt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  u8tt_pkg::dp_status_type sts,
   output u8tt_pkg::ctrl_cmd_type  cmd
);
   import u8tt_pkg::*;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_CHECK    = 3'd1;
   localparam logic [2:0] ST_SCAN     = 3'd2;
   localparam logic [2:0] ST_EMIT_NL  = 3'd3;
   localparam logic [2:0] ST_EMIT_TGT = 3'd4;
   localparam logic [2:0] ST_EMIT_CHR = 3'd5;

   logic [2:0] state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in       = state_ff;
      cmd.take       = 1'b0;
      cmd.scan_start = 1'b0;
      cmd.scan_step  = 1'b0;
      cmd.out_load   = 1'b0;
      cmd.out_sel    = OUT_SEL_NL;
      case (state_ff)
         ST_IDLE: begin
            cmd.take = req_tvalid;
            if (req_tvalid && sts.char_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.scan_start = 1'b1;
            if (sts.is_cr) begin
               state_in = ST_IDLE;
            end else if (sts.is_blank) begin
               state_in = ST_EMIT_NL;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // read data arrives in the cycle after its address; first hit wins
            if (sts.cmp_valid && sts.cmp_match) begin
               state_in = ST_EMIT_TGT;
            end else if (!sts.issued_all) begin
               cmd.scan_step = 1'b1;
            end else if (!sts.cmp_valid) begin
               state_in = ST_EMIT_CHR;
            end
         end
         ST_EMIT_NL: begin
            cmd.out_sel = OUT_SEL_NL;
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT_TGT: begin
            cmd.out_sel = OUT_SEL_TGT;
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_EMIT_CHR: begin
            cmd.out_sel = OUT_SEL_CHR;
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               if (sts.emit_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("output register overwritten");
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> !sts.issued_all)
      else $error("table read past entry count");
   a_done_to_check: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && sts.char_done) |=> (state_ff == ST_CHECK))
      else $error("completed character not classified");
   a_hit_no_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && sts.cmp_valid && sts.cmp_match) |-> !cmd.scan_step)
      else $error("scan continued past a hit");
`endif

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 character table transliterator. Bytes and
// table loads go in on the request stream; an in-bench model of the character
// grouping, blank/CR handling and first-match table lookup predicts every
// output byte, and each output beat is compared against the oldest prediction.
// Both stream sides idle at random; one long output hold-off fills the block.
// ----------------------------------------------------------------------------
module tb_top;
   import u8tt_pkg::*;

   localparam int TABLE_SLOTS     = 64;
   localparam int CHAR_MAX        = 8;
   localparam int LATENCY_PAUSE   = 100;   // covers a full table scan plus emit
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int WATCHDOG_LIMIT  = 3000;

   typedef struct packed {
      logic [7:0] value;
      logic       last_flag;
   } out_item_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [7:0]             rsp_tdata;
   logic                   rsp_tlast;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CFG_W-1:0]       csr_data;

   // model state
   logic [7:0]       char_buf [CHAR_MAX];
   int               held_count;
   int               char_len;
   logic [SRC_W-1:0] tab_source [TABLE_SLOTS];
   logic [LEN_W-1:0] tab_length [TABLE_SLOTS];
   logic [7:0]       tab_target [TABLE_SLOTS];
   logic [CFG_W-1:0] entry_limit;

   out_item_type pending_bytes [$];
   int        mismatch_count = 0;
   int        requests_sent  = 0;
   int        stall_cycles   = 0;
   bit        quiet          = 1'b0;
   bit        hold_rsp       = 1'b0;

   utf8_char_table_transliterator #(
      .TABLE_DEPTH    (TABLE_SLOTS),
      .MAX_CHAR_BYTES (CHAR_MAX)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- model

   function automatic int char_length_of(input logic [7:0] lead);
      int ones = 0;
      while (ones < 8 && lead[7 - ones]) ones++;
      if (ones == 0) return 1;
      return (ones > CHAR_MAX) ? CHAR_MAX : ones;
   endfunction

   task automatic transliterate_request(input logic kind,
                                        input logic [REQ_TDATA_W-1:0] payload);
      logic [INDEX_W-1:0] idx;
      logic [7:0]         b;
      int                 len;
      int                 limit;
      bit                 same;
      if (kind == REQ_LOAD) begin
         idx             = payload[INDEX_LSB +: INDEX_W];
         tab_target[idx] = payload[TARGET_LSB +: BYTE_W];
         tab_length[idx] = payload[LENGTH_LSB +: LEN_W];
         tab_source[idx] = payload[SOURCE_LSB +: SRC_W];
         return;
      end
      b = payload[DATA_LSB +: BYTE_W];
      if (held_count == 0) char_len = char_length_of(b);
      char_buf[held_count] = b;
      held_count++;
      if (held_count < char_len) return;
      len        = char_len;
      held_count = 0;
      char_len   = 0;
      if (len == 1 && char_buf[0] == CODE_CR) return;
      if (len == 1 && (char_buf[0] == CODE_LF || char_buf[0] == CODE_SPACE ||
                       char_buf[0] == CODE_TAB)) begin
         pending_bytes.push_back('{CODE_LF, 1'b1});
         return;
      end
      limit = (entry_limit > TABLE_SLOTS) ? TABLE_SLOTS : entry_limit;
      for (int e = 0; e < limit; e++) begin
         same = (tab_length[e] == len);
         for (int i = 0; i < len; i++)
            if (tab_source[e][8*i +: 8] != char_buf[i]) same = 1'b0;
         if (same) begin
            pending_bytes.push_back('{tab_target[e], 1'b1});
            return;
         end
      end
      for (int i = 0; i < len; i++)
         pending_bytes.push_back('{char_buf[i], (i == len - 1)});
   endtask

   // ------------------------------------------------------------- drivers

   task automatic send_request(input logic kind, input logic [REQ_TDATA_W-1:0] payload);
      int gap;
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= payload;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      transliterate_request(kind, payload);
      requests_sent++;
   endtask

   // unused fields carry random bits; the pad above the source stays zero
   function automatic logic [REQ_TDATA_W-1:0] noise_payload();
      logic [REQ_TDATA_W-1:0] p;
      p = {$urandom, $urandom, $urandom};
      p[REQ_TDATA_W-1:SOURCE_LSB+SRC_W] = '0;
      return p;
   endfunction

   task automatic send_data(input logic [7:0] value);
      logic [REQ_TDATA_W-1:0] p;
      p = noise_payload();
      p[DATA_LSB +: BYTE_W] = value;
      send_request(REQ_DATA, p);
   endtask

   task automatic send_load(input logic [INDEX_W-1:0] idx, input logic [7:0] target,
                            input logic [LEN_W-1:0] len, input logic [SRC_W-1:0] src);
      logic [REQ_TDATA_W-1:0] p;
      p = noise_payload();
      p[INDEX_LSB +: INDEX_W]  = idx;
      p[TARGET_LSB +: BYTE_W]  = target;
      p[LENGTH_LSB +: LEN_W]   = len;
      p[SOURCE_LSB +: SRC_W]   = src;
      send_request(REQ_LOAD, p);
   endtask

   task automatic send_char(input int len, input logic [63:0] word);
      for (int i = 0; i < len; i++) send_data(word[8*i +: 8]);
   endtask

   function automatic int random_len();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3) return 1;
      if (r < 5) return 2;
      if (r < 7) return 3;
      if (r < 8) return 4;
      return $urandom_range(5, CHAR_MAX);
   endfunction

   // lead byte shaped for the length, every other byte random
   function automatic logic [63:0] random_char(input int len);
      logic [63:0] w;
      logic [7:0]  lead;
      w = {$urandom, $urandom};
      if (len == 1)
         lead = 8'($urandom_range(0, 127));
      else
         lead = (8'hFF << (8 - len)) | (8'($urandom) & (8'hFF >> (len + 1)));
      w[7:0] = lead;
      return w;
   endfunction

   task automatic send_entry_char(input int e);
      int len;
      if (tab_length[e] >= 1 && tab_length[e] <= CHAR_MAX)
         len = tab_length[e];
      else
         len = char_length_of(tab_source[e][7:0]);
      send_char(len, tab_source[e]);
   endtask

   task automatic load_random_entry(input int idx, input bit odd);
      int               len;
      logic [LEN_W-1:0] len_field;
      len = random_len();
      if (!odd)
         len_field = LEN_W'(len);
      else if ($urandom_range(0, 1) == 0)
         len_field = '0;
      else
         len_field = LEN_W'($urandom_range(9, 15));
      send_load(INDEX_W'(idx), 8'($urandom), len_field, random_char(len));
   endtask

   // drop valid, let every expected byte drain, then give the block time to
   // finish work that produces no output
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (LATENCY_PAUSE) @(posedge clock);
   endtask

   task automatic set_entry_count(input logic [CFG_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      entry_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------- tests

   task automatic test_blank_and_control();
      set_entry_count('0);
      send_data(CODE_LF);
      send_data(CODE_SPACE);
      send_data(CODE_TAB);
      send_data(CODE_CR);
      send_data(8'h41);
      send_data(8'h00);
   endtask

   task automatic test_raw_characters();
      send_char(2, 64'h0000_0000_0000_A9C3);
      send_char(3, 64'h0000_0000_00AC_82E2);
      send_char(4, 64'h0000_0000_8098_9FF0);
      // all-ones lead; blank, CR and 0xFF bytes inside the character
      send_char(8, 64'h000D_0A20_FF80_41FF);
      send_data(8'h80);   // stray continuation byte stands alone
   endtask

   task automatic test_table_load();
      logic [63:0] word;
      for (int i = 0; i < TABLE_SLOTS; i++) load_random_entry(i, (i % 16) >= 13);
      word = random_char(1);
      word[7:0] = CODE_LF;
      send_load(INDEX_W'(2), 8'hC1, LEN_W'(1), word);
      word[7:0] = CODE_CR;
      send_load(INDEX_W'(3), 8'hC2, LEN_W'(1), word);
      send_load(INDEX_W'(7), 8'($urandom), LEN_W'(8), random_char(8));
      send_load(INDEX_W'(30), 8'($urandom), 4'd15, random_char(4));
      // later duplicate of entry 5: the earlier slot has to win
      send_load(INDEX_W'(40), ~tab_target[5], tab_length[5], tab_source[5]);
      // a load between the bytes of a character leaves the character intact
      word = random_char(4);
      send_char(3, word);
      load_random_entry(TABLE_SLOTS - 1, 1'b0);
      send_data(word[31:24]);
   endtask

   task automatic test_entry_matching();
      logic [63:0] word;
      int          len;
      set_entry_count(7'd64);
      send_entry_char(5);
      send_entry_char(40);
      send_entry_char(0);
      send_entry_char(7);
      send_entry_char(TABLE_SLOTS - 1);
      send_entry_char(2);
      send_entry_char(3);
      send_entry_char(13);
      send_entry_char(30);
      // one bit off in the final byte
      word = tab_source[10];
      len  = tab_length[10];
      word[8*(len-1)] = ~word[8*(len-1)];
      send_char(len, word);
   endtask

   task automatic test_entry_count_limits();
      set_entry_count(7'd1);
      send_entry_char(0);
      send_entry_char(1);
      set_entry_count(7'd127);
      send_entry_char(TABLE_SLOTS - 1);
      send_entry_char(40);
   endtask

   task automatic test_output_stall();
      int len;
      hold_rsp = 1'b1;
      repeat (3) begin
         len = $urandom_range(4, CHAR_MAX);
         send_char(len, random_char(len));
      end
   endtask

   // mostly whole characters, some table hits, some rewrites, broken leads
   task automatic random_burst(input int n_items);
      int          stop;
      int          r;
      int          len;
      logic [63:0] word;
      stop = requests_sent + n_items;
      while (requests_sent < stop) begin
         r = $urandom_range(0, 99);
         if (r < 40) begin
            send_entry_char($urandom_range(0, TABLE_SLOTS - 1));
         end else if (r < 65) begin
            len = random_len();
            send_char(len, random_char(len));
         end else if (r < 75) begin
            case ($urandom_range(0, 3))
               0: send_data(CODE_LF);
               1: send_data(CODE_SPACE);
               2: send_data(CODE_TAB);
               default: send_data(CODE_CR);
            endcase
         end else if (r < 85) begin
            load_random_entry($urandom_range(0, TABLE_SLOTS - 1), $urandom_range(0, 7) == 0);
         end else if (r < 93) begin
            len  = $urandom_range(2, CHAR_MAX);
            word = random_char(len);
            send_char($urandom_range(1, len - 1), word);
         end else begin
            send_data(8'($urandom));
         end
      end
   endtask

   task automatic test_random_traffic();
      set_entry_count(CFG_W'($urandom_range(2, 63)));
      random_burst(8);
      set_entry_count(7'd64);
      random_burst(8);
      set_entry_count(7'd127);
      random_burst(8);
   endtask

   task automatic test_steady_stream();
      quiet = 1'b1;
      random_burst(8);
   endtask

   // ------------------------------------------------------ result side

   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            for (int c = 0; c < RSP_HOLD_CYCLES; c++) @(negedge clock);
            hold_rsp = 1'b0;
            rsp_tready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      out_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_bytes.size() == 0) begin
            mismatch_count++;
            $display("%0t: out_byte expected none, actual %02h (last %0b)",
                     $time, rsp_tdata, rsp_tlast);
         end else begin
            want = pending_bytes.pop_front();
            if (rsp_tdata !== want.value) begin
               mismatch_count++;
               $display("%0t: out_byte expected %02h, actual %02h",
                        $time, want.value, rsp_tdata);
            end
            if (rsp_tlast !== want.last_flag) begin
               mismatch_count++;
               $display("%0t: last_of_run expected %0b, actual %0b",
                        $time, want.last_flag, rsp_tlast);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // ------------------------------------------------------------- main

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = REQ_DATA;
      csr_valid  = 1'b0;
      csr_data   = '0;
      held_count = 0;
      char_len   = 0;
      entry_limit = '0;
      for (int i = 0; i < CHAR_MAX; i++) char_buf[i] = '0;
      for (int i = 0; i < TABLE_SLOTS; i++) begin
         tab_source[i] = '0;
         tab_length[i] = '0;
         tab_target[i] = '0;
      end
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_blank_and_control();
      test_raw_characters();
      test_table_load();
      test_entry_matching();
      test_entry_count_limits();
      test_output_stall();
      test_random_traffic();
      test_steady_stream();

      wait_idle();
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
